FILE: hdl/irl_pkg.sv
`default_nettype none

package irl_pkg;

    localparam int ID_W         = 16;
    localparam int FUNC_W       = 3;
    localparam int CNT_W        = 17;
    localparam int STATIONS_DEF = 65536;
    localparam int PC_W         = 6;

    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REM_AFTER  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REM_BEFORE = 3'd4;

    localparam logic              ST_DONE    = 1'b0;
    localparam logic              ST_REFUSED = 1'b1;

    localparam logic [PC_W-1:0] PC_PROLOGUE     = 6'd0;
    localparam logic [PC_W-1:0] PC_APPEND       = 6'd4;
    localparam logic [PC_W-1:0] PC_APPEND_FIRST = 6'd9;
    localparam logic [PC_W-1:0] PC_INS_AFTER    = 6'd10;
    localparam logic [PC_W-1:0] PC_INS_BEFORE   = 6'd15;
    localparam logic [PC_W-1:0] PC_REM_AFTER    = 6'd20;
    localparam logic [PC_W-1:0] PC_REM_BEFORE   = 6'd29;
    localparam logic [PC_W-1:0] PC_REFUSE       = 6'd38;
    localparam logic [PC_W-1:0] PC_IGNORE       = 6'd39;

    typedef enum logic [1:0] {S_S, S_N, S_NB, S_FAR} t_ssrc;
    typedef enum logic [1:0] {C_NONE, C_S, C_N} t_cap;
    typedef enum logic [2:0] {
        LD_NONE, LD_NB_NEXT, LD_NB_PREV, LD_FAR_NEXT, LD_FAR_PREV
    } t_ld;
    typedef enum logic [1:0] {A_S, A_N, A_T, A_SLOT} t_asel;
    typedef enum logic [2:0] {D_S, D_N, D_NB, D_FAR, D_TAIL} t_dsel;
    typedef enum logic [1:0] {CNT_KEEP, CNT_UP, CNT_DOWN} t_cnt;
    typedef enum logic [1:0] {EM_NONE, EM_DONE, EM_REFUSE} t_emit;
    typedef enum logic [2:0] {J_NEXT, J_DISPATCH, J_IF_ZERO, J_IF_LE1, J_END} t_jump;

    typedef struct packed {
        t_ssrc            slot_src;
        t_cap             cap;
        t_asel            rd_addr;
        t_ld              ld;
        logic             wn_en;
        t_asel            wn_addr;
        t_dsel            wn_data;
        logic             wp_en;
        t_asel            wp_addr;
        t_dsel            wp_data;
        t_cnt             cnt;
        logic             tail_ld;
        t_emit            emit;
        t_jump            jump;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        slot_src: S_S, cap: C_NONE, rd_addr: A_S, ld: LD_NONE,
        wn_en: 1'b0, wn_addr: A_S, wn_data: D_S,
        wp_en: 1'b0, wp_addr: A_S, wp_data: D_S,
        cnt: CNT_KEEP, tail_ld: 1'b0, emit: EM_NONE,
        jump: J_NEXT, target: PC_PROLOGUE
    };

    function automatic logic [PC_W-1:0] entry_pc(input logic [FUNC_W-1:0] func);
        logic [PC_W-1:0] pc;
        case (func)
            FN_APPEND:     pc = PC_APPEND;
            FN_INS_AFTER:  pc = PC_INS_AFTER;
            FN_INS_BEFORE: pc = PC_INS_BEFORE;
            FN_REM_AFTER:  pc = PC_REM_AFTER;
            FN_REM_BEFORE: pc = PC_REM_BEFORE;
            default:       pc = PC_IGNORE;
        endcase
        return pc;
    endfunction

    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            // address of station, then of new station
            PC_PROLOGUE: begin
                w.slot_src = S_S;
            end
            PC_PROLOGUE + 6'd1: begin
                w.slot_src = S_N;
            end
            PC_PROLOGUE + 6'd2: begin
                w.cap = C_S;
            end
            PC_PROLOGUE + 6'd3: begin
                w.cap  = C_N;
                w.jump = J_DISPATCH;
            end
            // append
            PC_APPEND: begin
                w.rd_addr = A_T;
                w.jump    = J_IF_ZERO;
                w.target  = PC_APPEND_FIRST;
            end
            PC_APPEND + 6'd1: begin
                w.ld = LD_NB_NEXT;
            end
            PC_APPEND + 6'd2: begin
                w.slot_src = S_NB;
                w.wn_en    = 1'b1;
                w.wn_addr  = A_S;
                w.wn_data  = D_NB;
            end
            PC_APPEND + 6'd3: begin
                w.wp_en   = 1'b1;
                w.wp_addr = A_S;
                w.wp_data = D_TAIL;
                w.wn_en   = 1'b1;
                w.wn_addr = A_T;
                w.wn_data = D_S;
            end
            PC_APPEND + 6'd4: begin
                w.wp_en   = 1'b1;
                w.wp_addr = A_SLOT;
                w.wp_data = D_S;
                w.tail_ld = 1'b1;
                w.cnt     = CNT_UP;
                w.jump    = J_END;
            end
            PC_APPEND_FIRST: begin
                w.wn_en   = 1'b1;
                w.wn_addr = A_S;
                w.wn_data = D_S;
                w.wp_en   = 1'b1;
                w.wp_addr = A_S;
                w.wp_data = D_S;
                w.tail_ld = 1'b1;
                w.cnt     = CNT_UP;
                w.jump    = J_END;
            end
            // insert after
            PC_INS_AFTER: begin
                w.rd_addr = A_S;
            end
            PC_INS_AFTER + 6'd1: begin
                w.ld = LD_NB_NEXT;
            end
            PC_INS_AFTER + 6'd2: begin
                w.slot_src = S_NB;
                w.wn_en    = 1'b1;
                w.wn_addr  = A_N;
                w.wn_data  = D_NB;
                w.wp_en    = 1'b1;
                w.wp_addr  = A_N;
                w.wp_data  = D_S;
            end
            PC_INS_AFTER + 6'd3: begin
                w.wn_en   = 1'b1;
                w.wn_addr = A_S;
                w.wn_data = D_N;
            end
            PC_INS_AFTER + 6'd4: begin
                w.wp_en   = 1'b1;
                w.wp_addr = A_SLOT;
                w.wp_data = D_N;
                w.cnt     = CNT_UP;
                w.emit    = EM_DONE;
                w.jump    = J_END;
            end
            // insert before
            PC_INS_BEFORE: begin
                w.rd_addr = A_S;
            end
            PC_INS_BEFORE + 6'd1: begin
                w.ld = LD_NB_PREV;
            end
            PC_INS_BEFORE + 6'd2: begin
                w.slot_src = S_NB;
                w.wn_en    = 1'b1;
                w.wn_addr  = A_N;
                w.wn_data  = D_S;
                w.wp_en    = 1'b1;
                w.wp_addr  = A_N;
                w.wp_data  = D_NB;
            end
            PC_INS_BEFORE + 6'd3: begin
                w.wp_en   = 1'b1;
                w.wp_addr = A_S;
                w.wp_data = D_N;
            end
            PC_INS_BEFORE + 6'd4: begin
                w.wn_en   = 1'b1;
                w.wn_addr = A_SLOT;
                w.wn_data = D_N;
                w.cnt     = CNT_UP;
                w.emit    = EM_DONE;
                w.jump    = J_END;
            end
            // remove after
            PC_REM_AFTER: begin
                w.rd_addr = A_S;
            end
            PC_REM_AFTER + 6'd1: begin
                w.ld     = LD_NB_NEXT;
                w.jump   = J_IF_LE1;
                w.target = PC_REFUSE;
            end
            PC_REM_AFTER + 6'd2: begin
                w.slot_src = S_NB;
            end
            PC_REM_AFTER + 6'd4: begin
                w.rd_addr = A_SLOT;
            end
            PC_REM_AFTER + 6'd5: begin
                w.ld = LD_FAR_NEXT;
            end
            PC_REM_AFTER + 6'd6: begin
                w.slot_src = S_FAR;
                w.wn_en    = 1'b1;
                w.wn_addr  = A_S;
                w.wn_data  = D_FAR;
            end
            PC_REM_AFTER + 6'd8: begin
                w.wp_en   = 1'b1;
                w.wp_addr = A_SLOT;
                w.wp_data = D_S;
                w.cnt     = CNT_DOWN;
                w.emit    = EM_DONE;
                w.jump    = J_END;
            end
            // remove before
            PC_REM_BEFORE: begin
                w.rd_addr = A_S;
            end
            PC_REM_BEFORE + 6'd1: begin
                w.ld     = LD_NB_PREV;
                w.jump   = J_IF_LE1;
                w.target = PC_REFUSE;
            end
            PC_REM_BEFORE + 6'd2: begin
                w.slot_src = S_NB;
            end
            PC_REM_BEFORE + 6'd4: begin
                w.rd_addr = A_SLOT;
            end
            PC_REM_BEFORE + 6'd5: begin
                w.ld = LD_FAR_PREV;
            end
            PC_REM_BEFORE + 6'd6: begin
                w.slot_src = S_FAR;
                w.wp_en    = 1'b1;
                w.wp_addr  = A_S;
                w.wp_data  = D_FAR;
            end
            PC_REM_BEFORE + 6'd8: begin
                w.wn_en   = 1'b1;
                w.wn_addr = A_SLOT;
                w.wn_data = D_S;
                w.cnt     = CNT_DOWN;
                w.emit    = EM_DONE;
                w.jump    = J_END;
            end
            PC_REFUSE: begin
                w.emit = EM_REFUSE;
                w.jump = J_END;
            end
            PC_IGNORE: begin
                w.jump = J_END;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/irl_ram.sv
`default_nettype none

module irl_ram #(
    parameter int WIDTH = irl_pkg::ID_W,
    parameter int DEPTH = irl_pkg::STATIONS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/irl_slot.sv
`default_nettype none

module irl_slot #(
    parameter int STATIONS = irl_pkg::STATIONS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic [irl_pkg::ID_W-1:0]    i_id,
    output logic      [$clog2(STATIONS)-1:0] o_slot
);

    localparam int AW = $clog2(STATIONS);

    generate
        if (STATIONS >= (1 << irl_pkg::ID_W)) begin : g_pass
            logic [irl_pkg::ID_W-1:0] r_id;

            always_ff @(posedge i_clk) begin
                r_id   <= i_id;
                o_slot <= AW'(r_id);
            end
        end else begin : g_div
            // ceiling reciprocal gives an exact quotient for 16-bit ids
            localparam logic [31:0] RECIP =
                32'(((64'd1 << 32) + 64'(STATIONS) - 64'd1) / 64'(STATIONS));
            localparam logic [irl_pkg::ID_W-1:0] DIV = irl_pkg::ID_W'(STATIONS);

            logic [irl_pkg::ID_W-1:0]    r_id;
            logic [irl_pkg::ID_W+31:0]   r_prod;
            logic [irl_pkg::ID_W-1:0]    w_q;
            logic [2*irl_pkg::ID_W-1:0]  w_qd;
            logic [2*irl_pkg::ID_W-1:0]  w_rem;

            assign w_q   = r_prod[irl_pkg::ID_W+31:32];
            assign w_qd  = w_q * DIV;
            assign w_rem = {{irl_pkg::ID_W{1'b0}}, r_id} - w_qd;

            always_ff @(posedge i_clk) begin
                r_id   <= i_id;
                r_prod <= {32'd0, i_id} * {{irl_pkg::ID_W{1'b0}}, RECIP};
                o_slot <= w_rem[AW-1:0];
            end
        end
    endgenerate

endmodule

`default_nettype wire

FILE: hdl/indexed_ring_list_engine.sv
// Insert and remove end with a result strobe; append and an unknown code give none.
// The strobe comes in the first cycle that busy is low; a new item may start then.
// Busy time is set by the registered id-to-address unit and by registered RAM reads.
// Reset (synchronous, active low) empties the ring: count and tail go to zero.
// The next/prev memories are not cleared. The receiver cannot stall.
`default_nettype none

module indexed_ring_list_engine #(
    parameter int STATIONS = irl_pkg::STATIONS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [irl_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [irl_pkg::ID_W-1:0]     i_station,
    input  wire logic [irl_pkg::ID_W-1:0]     i_new_station,
    output logic                              o_valid,
    output logic      [irl_pkg::ID_W-1:0]     o_neighbour,
    output logic                              o_status
);

    localparam int AW = $clog2(STATIONS);
    localparam int IW = irl_pkg::ID_W;
    localparam int CW = irl_pkg::CNT_W;
    localparam int PW = irl_pkg::PC_W;

    logic                        r_run, n_run;
    logic [PW-1:0]               r_pc, n_pc;
    logic [irl_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [IW-1:0]               r_s, n_s;
    logic [IW-1:0]               r_n, n_n;
    logic [IW-1:0]               r_nb, n_nb;
    logic [IW-1:0]               r_far, n_far;
    logic [IW-1:0]               r_tail, n_tail;
    logic [AW-1:0]               r_as, n_as;
    logic [AW-1:0]               r_an, n_an;
    logic [AW-1:0]               r_at, n_at;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_valid, n_valid;
    logic [IW-1:0]               r_neighbour, n_neighbour;
    logic                        r_status, n_status;

    irl_pkg::t_uword             w_uw;
    logic [IW-1:0]               w_slot_in;
    logic [AW-1:0]               w_slot;
    logic [AW-1:0]               w_raddr;
    logic [AW-1:0]               w_wn_addr;
    logic [AW-1:0]               w_wp_addr;
    logic [IW-1:0]               w_wn_data;
    logic [IW-1:0]               w_wp_data;
    logic [IW-1:0]               w_next_q;
    logic [IW-1:0]               w_prev_q;
    logic                        w_wn_we;
    logic                        w_wp_we;

    assign w_uw = irl_pkg::uprog(r_pc);

    irl_slot #(
        .STATIONS (STATIONS)
    ) u_slot (
        .i_clk  (i_clk),
        .i_id   (w_slot_in),
        .o_slot (w_slot)
    );

    irl_ram #(
        .WIDTH (IW),
        .DEPTH (STATIONS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_wn_we),
        .i_waddr (w_wn_addr),
        .i_wdata (w_wn_data),
        .i_raddr (w_raddr),
        .o_rdata (w_next_q)
    );

    irl_ram #(
        .WIDTH (IW),
        .DEPTH (STATIONS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_wp_we),
        .i_waddr (w_wp_addr),
        .i_wdata (w_wp_data),
        .i_raddr (w_raddr),
        .o_rdata (w_prev_q)
    );

    assign w_wn_we = r_run && w_uw.wn_en;
    assign w_wp_we = r_run && w_uw.wp_en;

    always_comb begin
        case (w_uw.slot_src)
            irl_pkg::S_S:   w_slot_in = r_s;
            irl_pkg::S_N:   w_slot_in = r_n;
            irl_pkg::S_NB:  w_slot_in = r_nb;
            irl_pkg::S_FAR: w_slot_in = r_far;
            default:        w_slot_in = r_s;
        endcase
    end

    always_comb begin
        case (w_uw.rd_addr)
            irl_pkg::A_S:    w_raddr = r_as;
            irl_pkg::A_N:    w_raddr = r_an;
            irl_pkg::A_T:    w_raddr = r_at;
            irl_pkg::A_SLOT: w_raddr = w_slot;
            default:         w_raddr = r_as;
        endcase
        case (w_uw.wn_addr)
            irl_pkg::A_S:    w_wn_addr = r_as;
            irl_pkg::A_N:    w_wn_addr = r_an;
            irl_pkg::A_T:    w_wn_addr = r_at;
            irl_pkg::A_SLOT: w_wn_addr = w_slot;
            default:         w_wn_addr = r_as;
        endcase
        case (w_uw.wp_addr)
            irl_pkg::A_S:    w_wp_addr = r_as;
            irl_pkg::A_N:    w_wp_addr = r_an;
            irl_pkg::A_T:    w_wp_addr = r_at;
            irl_pkg::A_SLOT: w_wp_addr = w_slot;
            default:         w_wp_addr = r_as;
        endcase
    end

    always_comb begin
        case (w_uw.wn_data)
            irl_pkg::D_S:    w_wn_data = r_s;
            irl_pkg::D_N:    w_wn_data = r_n;
            irl_pkg::D_NB:   w_wn_data = r_nb;
            irl_pkg::D_FAR:  w_wn_data = r_far;
            irl_pkg::D_TAIL: w_wn_data = r_tail;
            default:         w_wn_data = r_s;
        endcase
        case (w_uw.wp_data)
            irl_pkg::D_S:    w_wp_data = r_s;
            irl_pkg::D_N:    w_wp_data = r_n;
            irl_pkg::D_NB:   w_wp_data = r_nb;
            irl_pkg::D_FAR:  w_wp_data = r_far;
            irl_pkg::D_TAIL: w_wp_data = r_tail;
            default:         w_wp_data = r_s;
        endcase
    end

    // sequencer: step counter and jumps
    always_comb begin
        n_run = r_run;
        n_pc  = r_pc;
        if (!r_run) begin
            if (start) begin
                n_run = 1'b1;
                n_pc  = irl_pkg::PC_PROLOGUE;
            end
        end else begin
            case (w_uw.jump)
                irl_pkg::J_NEXT: begin
                    n_pc = r_pc + PW'(1);
                end
                irl_pkg::J_DISPATCH: begin
                    n_pc = irl_pkg::entry_pc(r_func);
                end
                irl_pkg::J_IF_ZERO: begin
                    n_pc = (r_count == '0) ? w_uw.target : r_pc + PW'(1);
                end
                irl_pkg::J_IF_LE1: begin
                    n_pc = (r_count <= CW'(1)) ? w_uw.target : r_pc + PW'(1);
                end
                irl_pkg::J_END: begin
                    n_run = 1'b0;
                end
                default: begin
                    n_run = 1'b0;
                end
            endcase
        end
    end

    // datapath controls
    always_comb begin
        n_func      = r_func;
        n_s         = r_s;
        n_n         = r_n;
        n_nb        = r_nb;
        n_far       = r_far;
        n_tail      = r_tail;
        n_as        = r_as;
        n_an        = r_an;
        n_at        = r_at;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_neighbour = r_neighbour;
        n_status    = r_status;
        if (!r_run) begin
            if (start) begin
                n_func = i_func;
                n_s    = i_station;
                n_n    = i_new_station;
            end
        end else begin
            case (w_uw.cap)
                irl_pkg::C_S: n_as = w_slot;
                irl_pkg::C_N: n_an = w_slot;
                default: ;
            endcase
            case (w_uw.ld)
                irl_pkg::LD_NB_NEXT:  n_nb  = w_next_q;
                irl_pkg::LD_NB_PREV:  n_nb  = w_prev_q;
                irl_pkg::LD_FAR_NEXT: n_far = w_next_q;
                irl_pkg::LD_FAR_PREV: n_far = w_prev_q;
                default: ;
            endcase
            if (w_uw.tail_ld) begin
                n_tail = r_s;
                n_at   = r_as;
            end
            case (w_uw.cnt)
                irl_pkg::CNT_UP: begin
                    if (r_count != '1) begin
                        n_count = r_count + CW'(1);
                    end
                end
                irl_pkg::CNT_DOWN: begin
                    n_count = r_count - CW'(1);
                end
                default: ;
            endcase
            if (w_uw.emit != irl_pkg::EM_NONE) begin
                n_valid     = 1'b1;
                n_neighbour = r_nb;
                n_status    = (w_uw.emit == irl_pkg::EM_REFUSE) ? irl_pkg::ST_REFUSED
                                                                : irl_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pc    <= irl_pkg::PC_PROLOGUE;
            r_tail  <= '0;
            r_at    <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_pc    <= n_pc;
            r_tail  <= n_tail;
            r_at    <= n_at;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_s         <= n_s;
        r_n         <= n_n;
        r_nb        <= n_nb;
        r_far       <= n_far;
        r_as        <= n_as;
        r_an        <= n_an;
        r_neighbour <= n_neighbour;
        r_status    <= n_status;
    end

    assign busy        = r_run;
    assign o_valid     = r_valid;
    assign o_neighbour = r_neighbour;
    assign o_status    = r_status;

`ifndef SYNTH
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a finished item");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_pc == irl_pkg::PC_PROLOGUE))
        else $error("accepted item did not start the program");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && w_uw.cnt == irl_pkg::CNT_DOWN) |-> (r_count > CW'(1)))
        else $error("removal with fewer than two stations");

    a_refuse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == irl_pkg::ST_REFUSED) |-> $stable(r_count))
        else $error("refused removal changed the station count");
`endif

endmodule

`default_nettype wire
